[hw/rtl/tma_pkg.sv]
// Package for the tachometer moving-average block: widths, reset values,
// register indexes, FSM state codes and divider request/response types.
// No dependencies.
`timescale 1ns / 1ps

package tma_pkg;

  localparam int unsigned SAMPLES_DEF = 8;

  localparam int unsigned TPM_W  = 32;
  localparam int unsigned LIM_W  = 13;
  localparam int unsigned RPM_W  = 16;
  localparam int unsigned AVG_W  = 13;
  localparam int unsigned PER_W  = 32;
  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 32;

  localparam logic [TPM_W-1:0] TPM_RST  = 32'd60000000;
  localparam logic [LIM_W-1:0] LOW_RST  = 13'd100;
  localparam logic [LIM_W-1:0] HIGH_RST = 13'd6000;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_TPM  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_LOW  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_HIGH = 2'd2;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  // restoring divider widths and request/response types
  localparam int unsigned DIV_W  = 32;
  localparam int unsigned DIV_CW = $clog2(DIV_W + 1);

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_UPD  = 5'b00100,
    ST_AVGS = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

endpackage

[hw/rtl/tma_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tma_ram #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/tma_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tma_pkg.
`timescale 1ns / 1ps

module tma_div
  import tma_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DIV_W:0]    rem_q, rem_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [DIV_W-1:0]  dvs_q, dvs_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIV_W:0]    rem_sh;
  logic [DIV_W:0]    rem_sub;

  assign rem_sh  = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      cnt_d  = DIV_CW'(DIV_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!rem_sub[DIV_W]) begin
        rem_d = rem_sub;
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

[hw/rtl/tachometer_moving_average.sv]
// Tachometer top level: period-to-RPM conversion, range gate and moving average.
// Depends on tma_pkg, tma_ram, tma_div.
//
//   channel | signals                                   | direction
//   in      | in_valid_i/in_ready_o, mode_i, period_ticks_i | item in
//   out     | out_valid_o/out_ready_i, average_rpm_o, sample_rpm_o, accepted_o | result out
//   cfg     | cfg_we_i, cfg_addr_i, cfg_wdata_i          | register write
//
// A sample item runs from accept through the 32-step divider, then gate/update,
// average (reciprocal multiply) and output load, before its result is valid and
// the next item is accepted. Zero period skips the divider; a clear goes straight
// to the output load. One item is in flight; the next is taken once the result
// sits in the output register, and a stalled result holds the block in ST_DONE.
// Ring contents are cleared on reset by per-entry valid bits, so no clearing pass.
`timescale 1ns / 1ps

module tachometer_moving_average
  import tma_pkg::*;
#(
  parameter int unsigned SAMPLES = SAMPLES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              mode_i,
  input  logic [PER_W-1:0]  period_ticks_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [AVG_W-1:0]  average_rpm_o,
  output logic [RPM_W-1:0]  sample_rpm_o,
  output logic              accepted_o,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i
);

  localparam int unsigned IDX_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int unsigned TOT_W = LIM_W + $clog2(SAMPLES);

  // total / SAMPLES as (total * ceil(2^AVG_SH / SAMPLES)) >> AVG_SH; exact since
  // total * SAMPLES < 2^AVG_SH for every reachable total
  localparam int unsigned     AVG_SH  = TOT_W + $clog2(SAMPLES);
  localparam int unsigned     PROD_W  = TOT_W + AVG_SH + 1;
  localparam longint unsigned AVG_MUL =
    ((64'd1 << AVG_SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);

  state_e state_q, state_d;

  logic [TPM_W-1:0] tpm_q;
  logic [LIM_W-1:0] low_q, high_q;

  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [TOT_W-1:0]   total_q, total_d;
  logic [SAMPLES-1:0] vld_q, vld_d;

  logic [RPM_W-1:0] rpm_q, rpm_d;
  logic [AVG_W-1:0] avg_q, avg_d;
  logic             ok_q, ok_d;
  logic             out_valid_q, out_valid_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              in_acc;
  logic              out_free;
  logic              pass;
  logic [LIM_W-1:0]  old_val;
  logic [LIM_W-1:0]  ram_rdata;
  logic              ram_we;
  logic              ram_re;
  logic [RPM_W-1:0]  rpm_sat;
  logic [PROD_W-1:0] avg_prod;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign rpm_sat = (|div_rsp.quotient[DIV_W-1:RPM_W]) ? {RPM_W{1'b1}}
                                                       : div_rsp.quotient[RPM_W-1:0];
  assign pass    = (rpm_q > RPM_W'(low_q)) && (rpm_q < RPM_W'(high_q));
  assign old_val = vld_q[idx_q] ? ram_rdata : '0;

  assign avg_prod = PROD_W'(total_q) * PROD_W'(AVG_MUL);

  // the ring entry is read at accept and written back in ST_UPD; only one
  // item is in flight so the two never overlap
  assign ram_re = in_acc && (mode_i == MODE_SAMPLE) && (period_ticks_i != '0);
  assign ram_we = (state_q == ST_UPD) && pass;

  always_comb begin
    div_req.start    = ram_re;
    div_req.dividend = tpm_q;
    div_req.divisor  = period_ticks_i;
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    total_d     = total_q;
    vld_d       = vld_q;
    rpm_d       = rpm_q;
    avg_d       = avg_q;
    ok_d        = ok_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          rpm_d = '0;
          ok_d  = 1'b0;
          if (mode_i == MODE_CLEAR) begin
            idx_d   = '0;
            total_d = '0;
            vld_d   = '0;
            avg_d   = '0;
            state_d = ST_DONE;
          end else if (period_ticks_i == '0) begin
            state_d = ST_AVGS;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          rpm_d   = rpm_sat;
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (pass) begin
          total_d      = total_q - TOT_W'(old_val) + TOT_W'(rpm_q[LIM_W-1:0]);
          vld_d[idx_q] = 1'b1;
          idx_d        = (idx_q == IDX_W'(SAMPLES - 1)) ? '0 : idx_q + 1'b1;
          ok_d         = 1'b1;
        end
        state_d = ST_AVGS;
      end
      ST_AVGS: begin
        avg_d   = avg_prod[AVG_SH +: AVG_W];
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      total_q     <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      tpm_q       <= TPM_RST;
      low_q       <= LOW_RST;
      high_q      <= HIGH_RST;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      total_q     <= total_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_TPM:  tpm_q  <= cfg_wdata_i[TPM_W-1:0];
          REG_LOW:  low_q  <= cfg_wdata_i[LIM_W-1:0];
          REG_HIGH: high_q <= cfg_wdata_i[LIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rpm_q <= rpm_d;
    avg_q <= avg_d;
    ok_q  <= ok_d;
    if ((state_q == ST_DONE) && out_free) begin
      average_rpm_o <= avg_q;
      sample_rpm_o  <= rpm_q;
      accepted_o    <= ok_q;
    end
  end

  assign out_valid_o = out_valid_q;

  tma_ram #(
    .WIDTH (LIM_W),
    .DEPTH (SAMPLES)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (rpm_q[LIM_W-1:0]),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  tma_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule

[hw/rtl/tma_chk.sv]
// Port-level checker for the tachometer block, bound to the top level.
// Depends on tma_pkg.
`timescale 1ns / 1ps

module tma_chk
  import tma_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [AVG_W-1:0]  average_rpm_o,
  input logic [RPM_W-1:0]  sample_rpm_o,
  input logic              accepted_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(average_rpm_o) && $stable(sample_rpm_o) && $stable(accepted_o))
    else $error("result payload changed while stalled");

  // a stored speed is nonzero and below the 13-bit high limit
  a_acc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> (sample_rpm_o != '0) && (sample_rpm_o[RPM_W-1:LIM_W] == '0))
    else $error("accepted sample outside gate range");

  // one item in flight: input closes right after a transaction
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while busy");

endmodule

bind tachometer_moving_average tma_chk u_chk (.*);

[bench/tma_checker.sv]
// Checker for the tachometer moving-average block: watches the input, output
// and register-write ports, predicts each result and compares it field by field.
// Depends on tma_pkg.
`timescale 1ns / 1ps

module tma_checker
  import tma_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              mode_i,
  input  logic [PER_W-1:0]  period_ticks_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [AVG_W-1:0]  average_rpm_i,
  input  logic [RPM_W-1:0]  sample_rpm_i,
  input  logic              accepted_i,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  output int                fail_cnt_o,
  output int                pending_o
);

  localparam int unsigned RING_N = SAMPLES_DEF;

  typedef struct packed {
    logic [AVG_W-1:0] avg;
    logic [RPM_W-1:0] rpm;
    logic             acc;
  } speed_result_t;

  logic [TPM_W-1:0] tpm_q;
  logic [LIM_W-1:0] low_q;
  logic [LIM_W-1:0] high_q;
  logic [LIM_W-1:0] ring_q [RING_N];
  int unsigned      idx_q;
  logic [31:0]      total_q;

  speed_result_t expected_speed_q [$];
  int            n_in;
  int            n_out;

  initial fail_cnt_o = 0;
  assign pending_o = n_in - n_out;

  function automatic void clear_average_store();
    foreach (ring_q[k]) ring_q[k] = '0;
    idx_q   = 0;
    total_q = '0;
  endfunction

  // Converts one period to speed, applies the range gate and updates the ring, or clears it.
  function automatic speed_result_t predict_speed(input logic m, input logic [PER_W-1:0] p);
    speed_result_t r;
    logic [TPM_W-1:0] quo;
    r = '0;
    if (m == MODE_CLEAR) begin
      clear_average_store();
    end else if (p != '0) begin
      quo   = tpm_q / p;
      r.rpm = (quo > 32'h0000_FFFF) ? 16'hFFFF : quo[RPM_W-1:0];
      if (r.rpm > low_q && r.rpm < high_q) begin
        total_q       = total_q - ring_q[idx_q] + r.rpm[LIM_W-1:0];
        ring_q[idx_q] = r.rpm[LIM_W-1:0];
        idx_q         = (idx_q + 1) % RING_N;
        r.acc         = 1'b1;
      end
    end
    r.avg = AVG_W'(total_q / RING_N);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    fail_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    speed_result_t want;
    if (!rst_ni) begin
      tpm_q  = TPM_RST;
      low_q  = LOW_RST;
      high_q = HIGH_RST;
      clear_average_store();
      expected_speed_q.delete();
      n_in  <= 0;
      n_out <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_TPM:  tpm_q  = cfg_wdata_i[TPM_W-1:0];
          REG_LOW:  low_q  = cfg_wdata_i[LIM_W-1:0];
          REG_HIGH: high_q = cfg_wdata_i[LIM_W-1:0];
          default: ;
        endcase
      end
      // pop before push: a result leaving now never belongs to an item entering now
      if (out_valid_i && out_ready_i) begin
        n_out <= n_out + 1;
        if (expected_speed_q.size() == 0) begin
          report_mismatch("result transaction with no item outstanding");
        end else begin
          want = expected_speed_q.pop_front();
          if (average_rpm_i !== want.avg)
            report_mismatch($sformatf("average_rpm got %0d want %0d", average_rpm_i, want.avg));
          if (sample_rpm_i !== want.rpm)
            report_mismatch($sformatf("sample_rpm got %0d want %0d", sample_rpm_i, want.rpm));
          if (accepted_i !== want.acc)
            report_mismatch($sformatf("accepted got %0b want %0b", accepted_i, want.acc));
        end
      end
      if (in_valid_i && in_ready_i) begin
        n_in <= n_in + 1;
        expected_speed_q.push_back(predict_speed(mode_i, period_ticks_i));
      end
    end
  end

endmodule

[bench/tachometer_moving_average_tb.sv]
// Testbench top for tachometer_moving_average: clock, reset, period stimulus,
// register writes, output back-pressure and the verdict.
// Depends on tma_pkg, tma_checker and the block itself.
`timescale 1ns / 1ps

module tachometer_moving_average_tb;
  import tma_pkg::*;

  localparam logic [CFG_AW-1:0] REG_NONE = 2'd3;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_LIMIT  = 20_000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PHASES       = 7;
  localparam int unsigned PHASE_ITEMS  = 250;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_ready;
  logic              mode;
  logic [PER_W-1:0]  period_ticks;
  logic              out_valid;
  logic              out_ready;
  logic [AVG_W-1:0]  average_rpm;
  logic [RPM_W-1:0]  sample_rpm;
  logic              accepted;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;

  int          fail_cnt;
  int          pending;
  int unsigned cycle_cnt = 0;
  bit          idle_en = 1'b1;
  bit          hold_req = 1'b0;
  logic [TPM_W-1:0] tpm_now = TPM_RST;

  tachometer_moving_average u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mode_i         (mode),
    .period_ticks_i (period_ticks),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .average_rpm_o  (average_rpm),
    .sample_rpm_o   (sample_rpm),
    .accepted_o     (accepted),
    .cfg_we_i       (cfg_we),
    .cfg_addr_i     (cfg_addr),
    .cfg_wdata_i    (cfg_wdata)
  );

  tma_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .mode_i         (mode),
    .period_ticks_i (period_ticks),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .average_rpm_i  (average_rpm),
    .sample_rpm_i   (sample_rpm),
    .accepted_i     (accepted),
    .cfg_we_i       (cfg_we),
    .cfg_addr_i     (cfg_addr),
    .cfg_wdata_i    (cfg_wdata),
    .fail_cnt_o     (fail_cnt),
    .pending_o      (pending)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** tachometer_moving_average: FAILED **");
      $finish;
    end
  end

  // Result side: random or no back-pressure, or one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (idle_en) begin
        out_ready <= ($urandom_range(0, 99) >= 16);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic m, input logic [PER_W-1:0] p);
    in_valid     <= 1'b1;
    mode         <= m;
    period_ticks <= p;
    do @(posedge clk_i); while (!in_ready);
    if (idle_en && $urandom_range(0, 99) < 16) begin
      in_valid     <= 1'b0;
      mode         <= 1'($urandom);
      period_ticks <= $urandom;
      repeat ($urandom_range(1, 80)) @(posedge clk_i);
    end
  endtask

  // Stops offering items, then waits until every result is back.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Registers are only written with no transaction outstanding.
  task automatic set_config(input logic [TPM_W-1:0] tpm, input logic [LIM_W-1:0] lo,
                            input logic [LIM_W-1:0] hi);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_TPM;
    cfg_wdata <= tpm;
    @(posedge clk_i);
    cfg_addr  <= REG_LOW;
    cfg_wdata <= ($urandom << LIM_W) | CFG_DW'(lo);
    @(posedge clk_i);
    cfg_addr  <= REG_HIGH;
    cfg_wdata <= ($urandom << LIM_W) | CFG_DW'(hi);
    @(posedge clk_i);
    // unmapped index must not disturb anything
    cfg_addr  <= REG_NONE;
    cfg_wdata <= $urandom;
    @(posedge clk_i);
    cfg_we  <= 1'b0;
    tpm_now = tpm;
  endtask

  // Mostly periods aimed at a random speed so the range gate is hit from both sides.
  function automatic logic [PER_W-1:0] pick_period(input logic [TPM_W-1:0] tpm);
    logic [PER_W-1:0] p;
    int unsigned sel;
    int unsigned target;
    sel    = $urandom_range(0, 99);
    target = $urandom_range(1, 8191);
    if (sel < 8)       p = '0;
    else if (sel < 22) p = $urandom;
    else if (sel < 27) p = $urandom_range(1, 16);
    else               p = tpm / target + $urandom_range(0, 1);
    if (sel >= 8 && p == '0) p = 1;
    return p;
  endfunction

  initial begin
    int unsigned drain;
    logic [TPM_W-1:0] tpm;
    logic [LIM_W-1:0] lo;
    logic [LIM_W-1:0] hi;

    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    mode         = MODE_SAMPLE;
    period_ticks = '0;
    cfg_we       = 1'b0;
    cfg_addr     = REG_TPM;
    cfg_wdata    = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset register values
    send_item(MODE_CLEAR, 32'hFFFF_FFFF);
    send_item(MODE_SAMPLE, 32'd0);            // no pulse
    send_item(MODE_SAMPLE, 32'd1);            // saturates at 65535
    send_item(MODE_SAMPLE, 32'hFFFF_FFFF);    // zero speed
    send_item(MODE_SAMPLE, 32'd10000);        // exactly the high limit
    send_item(MODE_SAMPLE, 32'd10001);        // just below it
    send_item(MODE_SAMPLE, 32'd600000);       // exactly the low limit
    send_item(MODE_SAMPLE, 32'd594059);       // just above it
    repeat (8) send_item(MODE_SAMPLE, tpm_now / $urandom_range(101, 5999));
    send_item(MODE_CLEAR, 32'd0);
    send_item(MODE_SAMPLE, 32'd10001);
    wait_results_done();

    set_config(32'd0, 13'd0, 13'd8191);       // zero ticks per minute
    send_item(MODE_SAMPLE, 32'd5);
    wait_results_done();

    set_config(32'hFFFF_FFFF, 13'd0, 13'd8191);
    send_item(MODE_SAMPLE, 32'hFFFF_FFFF);
    send_item(MODE_SAMPLE, 32'd524352);       // lands on 8191
    send_item(MODE_SAMPLE, 32'd524353);       // lands on 8190
    wait_results_done();

    set_config(TPM_RST, 13'd5000, 13'd4000);  // inverted gate
    send_item(MODE_SAMPLE, 32'd13333);
    wait_results_done();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin tpm = TPM_RST; lo = LOW_RST; hi = HIGH_RST; end
        1: begin tpm = 32'd1_000_000; lo = 13'd0; hi = 13'd8191; end
        2: begin
          tpm = $urandom;
          lo  = $urandom_range(0, 2000);
          hi  = $urandom_range(3000, 8191);
        end
        3: begin tpm = 32'hFFFF_FFFF; lo = 13'd50; hi = 13'd8000; end
        4: begin tpm = $urandom; lo = 13'($urandom); hi = 13'($urandom); end
        5: begin tpm = 32'd480_000; lo = 13'd10; hi = 13'd400; end
        default: begin tpm = $urandom_range(1, 100_000); lo = 13'd0; hi = 13'd8191; end
      endcase
      set_config(tpm, lo, hi);
      idle_en = (ph != 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == 60) hold_req = 1'b1;
        if (ph == 3 && n == 100) begin
          in_valid <= 1'b0;
          wait_results_done();
        end
        if ($urandom_range(0, 99) < 3) send_item(MODE_CLEAR, $urandom);
        else                           send_item(MODE_SAMPLE, pick_period(tpm_now));
      end
      in_valid <= 1'b0;
      wait_results_done();
    end

    idle_en = 1'b1;
    drain = 0;
    do begin
      @(posedge clk_i);
      drain++;
    end while (pending != 0 && drain < DRAIN_LIMIT);
    repeat (200) @(posedge clk_i);

    if (fail_cnt == 0 && pending == 0) begin
      $display("** tachometer_moving_average: PASSED **");
    end else begin
      $display("** tachometer_moving_average: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/tma_pkg.sv
hw/rtl/tma_ram.sv
hw/rtl/tma_div.sv
hw/rtl/tachometer_moving_average.sv
hw/rtl/tma_chk.sv
bench/tma_checker.sv
bench/tachometer_moving_average_tb.sv
